/* rtl/hpr_pkg.sv */
// Package for the hyperbolic period reduction block: shared widths, types and
// the sequencer-to-MAC control struct. No dependencies.
package hpr_pkg;
  localparam int WordW = 40;
  localparam int CountW = 4;
  localparam int SlotW = 3;
  localparam int EntryW = 4;
  localparam int AppliedW = 5;
  localparam int SumW = 84;

  typedef logic signed [WordW-1:0] word_t;

  typedef enum logic [0:0] {
    CMD_LOAD   = 1'b0,
    CMD_REDUCE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ROW,
    ST_APPLY,
    ST_DONE
  } state_t;

  // Control from the sequencer to the multiply-accumulate datapath.
  typedef struct packed {
    logic clear;
    logic acc;
    logic chk;
    logic store;
  } mac_ctl_t;
endpackage

/* rtl/hpr_mac.sv */
// Multiply-accumulate datapath: one 40x40 product per cycle as two registered
// 40x20 partial products, truncated, summed and saturated to 40 bits. Uses hpr_pkg.
module hpr_mac #(
  parameter int FRAC_BITS = 24
) (
  input  logic                clk,
  input  hpr_pkg::mac_ctl_t   ctl,
  input  hpr_pkg::word_t      a,
  input  hpr_pkg::word_t      b,
  output hpr_pkg::word_t      sum_sat,
  output logic                sat
);
  import hpr_pkg::*;

  localparam int HalfW = WordW / 2;

  logic signed [WordW+HalfW:0]   pp_lo_r;
  logic signed [WordW+HalfW-1:0] pp_hi_r;
  logic signed [SumW-1:0]        acc_r;
  logic signed [SumW-1:0]        prod_full;
  logic signed [SumW-1:0]        prod_ext;
  logic signed [SumW-1:0]        acc_nxt;

  // The low half of b is taken as unsigned, the high half carries the sign.
  always_ff @(posedge clk) begin
    pp_lo_r <= a * signed'({1'b0, b[HalfW-1:0]});
    pp_hi_r <= a * signed'(b[WordW-1:HalfW]);
    acc_r   <= acc_nxt;
  end

  always_comb begin
    prod_full = (SumW'(pp_hi_r) <<< HalfW) + SumW'(pp_lo_r);
    prod_ext  = prod_full >>> FRAC_BITS;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.acc) begin
      acc_nxt = acc_r + prod_ext;
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_comb begin
    sat = 1'b0;
    if (acc_r > SumW'(signed'({1'b0, {(WordW-1){1'b1}}}))) begin
      sum_sat = {1'b0, {(WordW-1){1'b1}}};
      sat = 1'b1;
    end else if (acc_r < -SumW'(signed'({1'b0, 1'b1, {(WordW-1){1'b0}}}))) begin
      sum_sat = {1'b1, {(WordW-1){1'b0}}};
      sat = 1'b1;
    end else begin
      sum_sat = acc_r[WordW-1:0];
    end
  end
endmodule

/* rtl/hyperbolic_period_reduction_top.sv */
// Hyperbolic period reduction top level: period memory, sequencer and MAC.
// A reduce beat runs slot checks over all rounds, each preceded by a decision; a row
// sum goes through the one read port and the single MAC.
// One point is in work at a time; the next beat is taken once the result leaves.
// Reset (rst_n, synchronous, low) clears control and period_count only.
module hyperbolic_period_reduction_top #(
  parameter int MAX_PERIODS = 8,
  parameter int ROUND_LIMIT = 30,
  parameter int FRAC_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [hpr_pkg::SlotW-1:0]   in_slot,
  input  logic [hpr_pkg::EntryW-1:0]  in_entry,
  input  hpr_pkg::word_t              in_word,
  input  hpr_pkg::word_t              in_px,
  input  hpr_pkg::word_t              in_py,
  input  hpr_pkg::word_t              in_pz,
  output logic                        out_valid,
  input  logic                        out_stall,
  output hpr_pkg::word_t              out_rx,
  output hpr_pkg::word_t              out_ry,
  output hpr_pkg::word_t              out_rz,
  output logic [hpr_pkg::AppliedW-1:0] out_applied,
  output logic                        out_limit_hit,
  output logic                        out_saturated,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hpr_pkg::CountW-1:0]  cfg_data
);
  import hpr_pkg::*;

  localparam int Depth = MAX_PERIODS * 9;
  localparam int AddrW = $clog2(Depth);
  localparam int KW = $clog2(MAX_PERIODS + 1);
  localparam int RW = $clog2(ROUND_LIMIT + 1);

  // Period memory, one write and one registered read port.
  word_t mem [Depth];
  word_t rd_r;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_word;
    rd_r <= mem[rd_addr];
  end

  logic [CountW-1:0] count_r;
  state_t state_r, state_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [1:0] row_r, row_nxt;     // row being summed
  logic [2:0] ph_r, ph_nxt;       // phase within a row: read / mul / acc
  logic [RW-1:0] rounds_r, rounds_nxt;
  word_t p_r [3];
  word_t q_r [3];
  logic sat_r, sat_nxt;
  logic [KW-1:0] cnt_eff;
  mac_ctl_t ctl;
  word_t sum_sat;
  logic mac_sat;
  logic out_full_r;
  logic accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE) || out_full_r;
  assign accept    = in_valid && !in_stall;
  assign cnt_eff   = (32'(count_r) > MAX_PERIODS) ? KW'(MAX_PERIODS) : KW'(count_r);
  assign wr_en     = accept && (in_cmd == CMD_LOAD) && (32'(in_slot) < MAX_PERIODS)
                     && (in_entry < 4'd9);
  assign wr_addr   = AddrW'(32'(in_slot) * 9 + 32'(in_entry));

  // Row being evaluated: in ST_SCAN only row 2; in ST_APPLY rows 0..2.
  // Phases 0..2 issue reads for columns; each read lands in the following phase,
  // and its product in the phase after that.
  always_comb begin
    rd_addr = AddrW'(32'(k_r) * 9 + 32'(row_r) * 3 + ((ph_r < 3'd3) ? 32'(ph_r) : 0));
  end

  // MAC sees memory word (rd_r) times point coordinate in phases 1..3 (reads
  // of columns 0..2 land then); products accumulate in phases 2..4.
  word_t mac_a;
  word_t mac_bb;
  always_comb begin
    mac_a  = rd_r;
    unique case (ph_r)
      3'd1:    mac_bb = p_r[0];
      3'd2:    mac_bb = p_r[1];
      default: mac_bb = p_r[2];
    endcase
    ctl.clear = (ph_r == 3'd0);
    ctl.acc   = (ph_r >= 3'd2) && (ph_r <= 3'd4);
    ctl.chk   = (ph_r == 3'd5);
    ctl.store = (ph_r == 3'd5);
  end

  hpr_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk(clk), .ctl(ctl), .a(mac_a), .b(mac_bb), .sum_sat(sum_sat), .sat(mac_sat)
  );

  // Next state and counters.
  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    row_nxt    = row_r;
    ph_nxt     = ph_r;
    rounds_nxt = rounds_r;
    sat_nxt    = sat_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_cmd == CMD_REDUCE) begin
          k_nxt = '0; row_nxt = 2'd2; ph_nxt = '0; rounds_nxt = RW'(1);
          state_nxt = ST_ROW;
        end
      end
      ST_ROW: begin
        // Decide: round limit or next slot check or done.
        if (32'(rounds_r) >= ROUND_LIMIT) state_nxt = ST_DONE;
        else if (k_r >= cnt_eff) state_nxt = ST_DONE;
        else begin
          row_nxt = 2'd2; ph_nxt = '0; state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ph_nxt = ph_r + 3'd1;
        if (ctl.chk) begin
          ph_nxt = '0;
          if (mac_sat) sat_nxt = 1'b1;
          if (sum_sat < p_r[2]) begin
            row_nxt = 2'd0; state_nxt = ST_APPLY;
          end else begin
            k_nxt = k_r + KW'(1); state_nxt = ST_ROW;
          end
        end
      end
      ST_APPLY: begin
        ph_nxt = ph_r + 3'd1;
        if (ctl.chk) begin
          ph_nxt = '0;
          if (mac_sat) sat_nxt = 1'b1;
          if (row_r == 2'd2) begin
            k_nxt = '0; rounds_nxt = rounds_r + RW'(1); state_nxt = ST_ROW;
          end else begin
            row_nxt = row_r + 2'd1;
          end
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (state_r == ST_IDLE && accept && in_cmd == CMD_REDUCE) sat_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      out_full_r <= 1'b0;
      k_r <= '0; row_r <= '0; ph_r <= '0; rounds_r <= '0; sat_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r <= k_nxt; row_r <= row_nxt; ph_r <= ph_nxt;
      rounds_r <= rounds_nxt; sat_r <= sat_nxt;
      if (cfg_valid && cfg_ready) count_r <= cfg_data;
      if (state_r == ST_DONE) out_full_r <= 1'b1;
      else if (out_valid && !out_stall) out_full_r <= 1'b0;
    end
  end

  // Point registers: loaded on a reduce accept, updated after row 2 of an apply.
  // The applied count saturates at the top of its field.
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept && in_cmd == CMD_REDUCE) begin
      p_r[0] <= in_px; p_r[1] <= in_py; p_r[2] <= in_pz;
    end
    if (state_r == ST_APPLY && ctl.store) begin
      q_r[row_r] <= sum_sat;
      if (row_r == 2'd2) begin
        p_r[0] <= q_r[0]; p_r[1] <= q_r[1]; p_r[2] <= sum_sat;
      end
    end
    if (state_r == ST_DONE) begin
      out_rx <= p_r[0]; out_ry <= p_r[1]; out_rz <= p_r[2];
      if (32'(rounds_r) > 32) out_applied <= {AppliedW{1'b1}};
      else out_applied <= AppliedW'(rounds_r - RW'(1));
      out_limit_hit <= (32'(rounds_r) >= ROUND_LIMIT);
      out_saturated <= sat_r;
    end
  end

  assign out_valid = out_full_r;
endmodule

/* rtl/hpr_checker.sv */
// Port-level checker for the hyperbolic period reduction top level, with its
// bind statement. Depends on hyperbolic_period_reduction_top.
module hpr_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [4:0] out_applied,
  input logic out_limit_hit
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken with result pending");
  a_applied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_applied <= 5'd29) else $error("applied beyond round limit");
  a_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_limit_hit |-> out_applied < 5'd29) else $error("limit flag wrong");
endmodule

bind hyperbolic_period_reduction_top hpr_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_applied(out_applied),
  .out_limit_hit(out_limit_hit)
);
